@@ sv/fvl_pkg.sv @@
// shared constants and the divider flags type for the feedforward velocity limiter
`timescale 1ns / 1ps

package fvl_pkg;

  localparam int unsigned NUM_W  = 64;
  localparam int unsigned KA_W   = 31;
  localparam int unsigned CFG_AW = 3;

  // pi/30 in unsigned q0.32
  localparam logic [28:0] RPM_TO_RAD = 29'd449767923;

  localparam logic [CFG_AW-1:0] CFG_MAX_VOLTAGE = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_KV_GAIN     = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_KS_GAIN     = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KA_GAIN     = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_STEP_TIME   = 3'd4;

  localparam logic [19:0] MAX_VOLTAGE_RST = 20'd786432;
  localparam logic [30:0] KV_GAIN_RST     = 31'd65536;
  localparam logic [30:0] KS_GAIN_RST     = 31'd65536;
  localparam logic [30:0] KA_GAIN_RST     = 31'd65536;
  localparam logic [16:0] STEP_TIME_RST   = 17'd655;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_flags_t;

endpackage

@@ sv/fvl_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module fvl_divider #(
  parameter int unsigned QB = 49
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [fvl_pkg::NUM_W-1:0]    num_i,
  input  logic        [fvl_pkg::KA_W-1:0]     ka_i,
  output logic        [QB-1:0]                q_o,
  output fvl_pkg::div_flags_t                 flags_o
);
  import fvl_pkg::*;

  logic [KA_W-1:0]  ka_eff;
  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] top;

  logic [KA_W-1:0] r_q  [QB];
  logic [QB-1:0]   lo_q [QB];
  logic [QB-1:0]   q_q  [QB+1];
  div_flags_t      fl_q [QB+1];

  assign ka_eff = (ka_i == '0) ? KA_W'(1) : ka_i;
  assign mag    = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign top    = mag >> QB;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]      <= top[KA_W-1:0];
      lo_q[0]     <= mag[QB-1:0];
      q_q[0]      <= '0;
      fl_q[0].neg <= num_i[NUM_W-1];
      fl_q[0].ovf <= (top >= NUM_W'(ka_eff));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [KA_W:0] r_ext;
    logic          ge;
    logic [KA_W:0] r_sub;

    always_comb begin
      r_ext = {r_q[k-1], lo_q[k-1][QB-1]};
      ge    = (r_ext >= {1'b0, ka_eff});
      r_sub = ge ? (r_ext - {1'b0, ka_eff}) : r_ext;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]  <= {q_q[k-1][QB-2:0], ge};
        fl_q[k] <= fl_q[k-1];
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k]  <= r_sub[KA_W-1:0];
          lo_q[k] <= lo_q[k-1] << 1;
        end
      end
    end
  end

  assign q_o     = q_q[QB];
  assign flags_o = fl_q[QB];

endmodule

@@ sv/feedforward_velocity_limiter_core.sv @@
// top level: acceleration limited velocity clamp with deadband
//
//  channel | signals                                        | dir
//  in      | in_valid_i in_ready_o measured_rpm_i            | in
//          | desired_velocity_i                             |
//  out     | out_valid_o out_ready_i bounded_velocity_o      | out
//          | lower_limit_o upper_limit_o was_clamped_o       |
//          | in_deadband_o                                  |
//  cfg     | cfg_valid_i cfg_ready_o cfg_addr_i cfg_data_i   | in
//
// one beat per cycle in and out while the output is not stalled
// the divider has 33 + FRAC_BITS stages, one quotient bit per stage
// reset restores the register defaults and empties the pipeline
// a stalled output freezes the whole pipeline, nothing is lost or repeated
`timescale 1ns / 1ps

module feedforward_velocity_limiter_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            measured_rpm_i,
  input  logic signed [31:0]            desired_velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            bounded_velocity_o,
  output logic signed [31:0]            lower_limit_o,
  output logic signed [31:0]            upper_limit_o,
  output logic                          was_clamped_o,
  output logic                          in_deadband_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fvl_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [31:0]                   cfg_data_i
);
  import fvl_pkg::*;

  localparam int unsigned QB = 33 + FRAC_BITS;
  localparam int unsigned AW = QB + 1;
  localparam int unsigned HW = AW - 32;
  localparam int unsigned PW = AW + 18;
  localparam int unsigned SW = PW - FRAC_BITS;
  localparam int unsigned NV = QB + 12;

  // configuration registers
  logic [19:0] max_q;
  logic [30:0] kv_q;
  logic [30:0] ks_q;
  logic [30:0] ka_q;
  logic [16:0] dt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_VOLTAGE_RST;
      kv_q  <= KV_GAIN_RST;
      ks_q  <= KS_GAIN_RST;
      ka_q  <= KA_GAIN_RST;
      dt_q  <= STEP_TIME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MAX_VOLTAGE: max_q <= cfg_data_i[19:0];
        CFG_KV_GAIN:     kv_q  <= cfg_data_i[30:0];
        CFG_KS_GAIN:     ks_q  <= cfg_data_i[30:0];
        CFG_KA_GAIN:     ka_q  <= cfg_data_i[30:0];
        CFG_STEP_TIME:   dt_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          en;
  logic [NV-1:0] vld_q;

  assign en          = !vld_q[NV-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  logic signed [63:0] vmax_f;
  logic signed [63:0] ks_f;
  logic        [63:0] thr;

  assign vmax_f = $signed(64'(max_q) << FRAC_BITS);
  assign ks_f   = $signed(64'(ks_q) << FRAC_BITS);
  assign thr    = 64'(ks_f) * 64'd6;

  // stages 1 to 4: rpm conversion, v*kv, numerators
  logic signed [61:0] p1_q;
  logic signed [31:0] des1_q, des2_q, des3_q, des4_q;
  logic signed [31:0] v2_q, v3_q, v4_q;
  logic signed [62:0] vk3_q;
  logic signed [63:0] num4_q [4];

  logic signed [61:0] p1_d;
  logic signed [61:0] rnd;
  logic signed [63:0] base_f, base_r;
  logic               v_pos, v_neg, d_pos, d_neg;
  logic signed [63:0] num4_d [4];
  logic [3:0]         s_pos, s_neg;

  always_comb begin
    p1_d   = $signed(measured_rpm_i) * $signed({1'b0, RPM_TO_RAD});
    rnd    = p1_q + (62'sd1 <<< 31);
    base_f = vmax_f - 64'(vk3_q);
    base_r = -vmax_f - 64'(vk3_q);
    v_pos  = (v3_q > 0);
    v_neg  = v3_q[31];
    d_pos  = (des3_q > 0);
    d_neg  = des3_q[31];
    if (v_pos || v_neg) begin
      s_pos = {4{v_pos}};
      s_neg = {4{v_neg}};
    end else begin
      s_pos = {1'b1, 1'b0, d_pos, d_pos};
      s_neg = {1'b0, 1'b1, d_neg, d_neg};
    end
    for (int i = 0; i < 4; i++) begin
      num4_d[i] = ((i == 0) || (i == 3)) ? base_f : base_r;
      if (s_pos[i]) begin
        num4_d[i] = num4_d[i] - ks_f;
      end else if (s_neg[i]) begin
        num4_d[i] = num4_d[i] + ks_f;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= p1_d;
      des1_q <= desired_velocity_i;
      v2_q   <= 32'($signed(rnd[61:32]));
      des2_q <= des1_q;
      vk3_q  <= v2_q * $signed({1'b0, kv_q});
      v3_q   <= v2_q;
      des3_q <= des2_q;
      num4_q <= num4_d;
      v4_q   <= v3_q;
      des4_q <= des3_q;
    end
  end

  // dividers, one lane per bound
  logic [QB-1:0] q_div  [4];
  div_flags_t    fl_div [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    fvl_divider #(.QB(QB)) u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .num_i   (num4_q[l]),
      .ka_i    (ka_q),
      .q_o     (q_div[l]),
      .flags_o (fl_div[l])
    );
  end

  logic signed [31:0] sd_v_q   [QB+1];
  logic signed [31:0] sd_des_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_v_q[0]   <= v4_q;
      sd_des_q[0] <= des4_q;
      for (int i = 1; i <= QB; i++) begin
        sd_v_q[i]   <= sd_v_q[i-1];
        sd_des_q[i] <= sd_des_q[i-1];
      end
    end
  end

  // stages a to d: bound = v + floor(acc * dt), saturated to 32 bits
  logic signed [AW-1:0]    acc_a_q [4];
  div_flags_t              fl_a_q  [4];
  logic        [48:0]      plo_b_q [4];
  logic signed [HW+17:0]   phi_b_q [4];
  div_flags_t              fl_b_q  [4];
  logic signed [SW-1:0]    sh_c_q  [4];
  div_flags_t              fl_c_q  [4];
  logic signed [31:0]      bnd_d_q [4];
  logic signed [31:0]      v_a_q, v_b_q, v_c_q;
  logic signed [31:0]      des_a_q, des_b_q, des_c_q, des_d_q;

  logic signed [PW-1:0]    prod_c [4];
  logic signed [SW:0]      sum_d  [4];
  logic signed [31:0]      bnd_d  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_c[i] = ($signed(PW'(phi_b_q[i])) <<< 32) + $signed(PW'(plo_b_q[i]));
      sum_d[i]  = (SW+1)'(sh_c_q[i]) + (SW+1)'(v_c_q);
      if (dt_q == '0) begin
        bnd_d[i] = v_c_q;
      end else if (fl_c_q[i].ovf) begin
        bnd_d[i] = fl_c_q[i].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (sum_d[i][SW:31] != {(SW-30){sum_d[i][31]}}) begin
        bnd_d[i] = sum_d[i][SW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        bnd_d[i] = sum_d[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        acc_a_q[i] <= fl_div[i].neg ? -$signed({1'b0, q_div[i]}) : $signed({1'b0, q_div[i]});
        fl_a_q[i]  <= fl_div[i];
        plo_b_q[i] <= 49'(acc_a_q[i][31:0]) * 49'(dt_q);
        phi_b_q[i] <= $signed(acc_a_q[i][AW-1:32]) * $signed({1'b0, dt_q});
        fl_b_q[i]  <= fl_a_q[i];
        sh_c_q[i]  <= prod_c[i][PW-1:FRAC_BITS];
        fl_c_q[i]  <= fl_b_q[i];
        bnd_d_q[i] <= bnd_d[i];
      end
      v_a_q   <= sd_v_q[QB];
      des_a_q <= sd_des_q[QB];
      v_b_q   <= v_a_q;
      des_b_q <= des_a_q;
      v_c_q   <= v_b_q;
      des_c_q <= des_b_q;
      des_d_q <= des_c_q;
    end
  end

  // stages e to g: clamp, magnitude times kv, deadband
  logic signed [31:0] c_e_q, c_f_q;
  logic               clmp_e_q, clmp_f_q;
  logic signed [31:0] lower_e_q, lower_f_q, upper_e_q, upper_f_q;
  logic        [62:0] pk_f_q;

  logic signed [31:0] c_e;
  logic               clmp_e;
  logic        [32:0] negc;
  logic        [31:0] mag_f;
  logic               dead_g;

  always_comb begin
    c_e    = des_d_q;
    clmp_e = 1'b0;
    if (des_d_q < bnd_d_q[1]) begin
      c_e    = bnd_d_q[1];
      clmp_e = 1'b1;
    end else if (des_d_q > bnd_d_q[0]) begin
      c_e    = bnd_d_q[0];
      clmp_e = 1'b1;
    end
    negc   = -{c_e_q[31], c_e_q};
    mag_f  = c_e_q[31] ? negc[31:0] : c_e_q;
    dead_g = (pk_f_q <= 63'(64'd1 << 60)) && ((64'(pk_f_q) * 64'd5) < thr);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_e_q              <= c_e;
      clmp_e_q           <= clmp_e;
      lower_e_q          <= bnd_d_q[2];
      upper_e_q          <= bnd_d_q[3];
      pk_f_q             <= 63'(mag_f) * 63'(kv_q);
      c_f_q              <= c_e_q;
      clmp_f_q           <= clmp_e_q;
      lower_f_q          <= lower_e_q;
      upper_f_q          <= upper_e_q;
      bounded_velocity_o <= dead_g ? 32'sd0 : c_f_q;
      lower_limit_o      <= lower_f_q;
      upper_limit_o      <= upper_f_q;
      was_clamped_o      <= clmp_f_q;
      in_deadband_o      <= dead_g;
    end
  end

endmodule

@@ sv/fvl_checker.sv @@
// port level checks for the feedforward velocity limiter
`timescale 1ns / 1ps

module fvl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [31:0]         bounded_velocity_o,
  input logic                       in_deadband_o,
  input logic                       cfg_ready_o
);

  // input side only waits on a held result
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stall");

  // deadband beats carry zero velocity
  a_deadband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_deadband_o) |-> (bounded_velocity_o == 32'sd0))
    else $error("deadband beat with nonzero velocity");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(bounded_velocity_o)))
    else $error("stalled output beat changed");

  // register port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind feedforward_velocity_limiter_core fvl_checker u_fvl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .bounded_velocity_o (bounded_velocity_o),
  .in_deadband_o      (in_deadband_o),
  .cfg_ready_o        (cfg_ready_o)
);
